[rtl/fcsd_pkg.sv]
// Shared constants and types of the flash command sequence decoder.
package fcsd_pkg;

  localparam int ADDRESS_BITS   = 18;
  localparam int SECTOR_BITS    = 12;
  localparam int BLOCK_BITS     = 14;
  localparam int BYTE_BITS      = 8;
  localparam int ACTION_BITS    = 3;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [ADDRESS_BITS-1:0] UNLOCK_A = ADDRESS_BITS'(32'h0000_5555);
  localparam logic [ADDRESS_BITS-1:0] UNLOCK_B = ADDRESS_BITS'(32'h0000_2AAA);
  localparam logic [ADDRESS_BITS-1:0] ID_ADDR_MFR = '0;
  localparam logic [ADDRESS_BITS-1:0] ID_ADDR_DEV = ADDRESS_BITS'(1);

  localparam logic [ADDRESS_BITS-1:0] SECTOR_MASK =
    ~ADDRESS_BITS'((64'd1 << SECTOR_BITS) - 64'd1);
  localparam logic [ADDRESS_BITS-1:0] BLOCK_MASK =
    ~ADDRESS_BITS'((64'd1 << BLOCK_BITS) - 64'd1);

  localparam logic [BYTE_BITS-1:0] DATA_UNLOCK_A = 8'hAA;
  localparam logic [BYTE_BITS-1:0] DATA_UNLOCK_B = 8'h55;
  localparam logic [BYTE_BITS-1:0] CMD_PROGRAM   = 8'hA0;
  localparam logic [BYTE_BITS-1:0] CMD_ID_ENTRY  = 8'h90;
  localparam logic [BYTE_BITS-1:0] CMD_ERASE     = 8'h80;
  localparam logic [BYTE_BITS-1:0] CMD_RESET     = 8'hF0;
  localparam logic [BYTE_BITS-1:0] CMD_BLOCK     = 8'h50;
  localparam logic [BYTE_BITS-1:0] CMD_SECTOR    = 8'h30;
  localparam logic [BYTE_BITS-1:0] CMD_CHIP      = 8'h10;

  localparam logic [BYTE_BITS-1:0] MFR_RESET = 8'hBF;
  localparam logic [BYTE_BITS-1:0] DEV_RESET = 8'h52;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MANUFACTURER = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEVICE       = 1'b1;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NONE    = 3'd0,
    ACT_PROGRAM = 3'd1,
    ACT_SECTOR  = 3'd2,
    ACT_BLOCK   = 3'd3,
    ACT_CHIP    = 3'd4,
    ACT_ARRAY   = 3'd5,
    ACT_ID      = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    STEP_IDLE    = 4'b0001,
    STEP_UNLOCK1 = 4'b0010,
    STEP_UNLOCK2 = 4'b0100,
    STEP_PROGRAM = 4'b1000
  } step_t;

  typedef struct packed {
    step_t step;
    logic  erase_armed;
    logic  id_mode;
  } seq_state_t;

  typedef struct packed {
    action_t                 action;
    logic [ADDRESS_BITS-1:0] action_address;
    logic [BYTE_BITS-1:0]    action_byte;
    logic                    in_id_mode;
    logic                    sequence_error;
  } result_t;

endpackage

[rtl/fcsd_decode.sv]
// Combinational decode of one bus access against the command sequence state.
module fcsd_decode (
  input  fcsd_pkg::seq_state_t                  state,
  input  logic                                  operation,
  input  logic [fcsd_pkg::ADDRESS_BITS-1:0]     address,
  input  logic [fcsd_pkg::BYTE_BITS-1:0]        data,
  input  logic [fcsd_pkg::BYTE_BITS-1:0]        manufacturer_code,
  input  logic [fcsd_pkg::BYTE_BITS-1:0]        device_code,
  output fcsd_pkg::seq_state_t                  state_nxt,
  output fcsd_pkg::result_t                     result
);
  import fcsd_pkg::*;

  logic err;

  always_comb begin
    state_nxt             = state;
    err                   = 1'b0;
    result.action         = ACT_NONE;
    result.action_address = '0;
    result.action_byte    = '0;

    if (operation == OP_READ) begin
      if (state.id_mode && address == ID_ADDR_MFR) begin
        result.action      = ACT_ID;
        result.action_byte = manufacturer_code;
      end else if (state.id_mode && address == ID_ADDR_DEV) begin
        result.action      = ACT_ID;
        result.action_byte = device_code;
      end else begin
        result.action         = ACT_ARRAY;
        result.action_address = address;
      end
    end else if (state.step == STEP_PROGRAM) begin
      // Any write while armed is the program byte, including F0.
      result.action         = ACT_PROGRAM;
      result.action_address = address;
      result.action_byte    = data;
      state_nxt.step        = STEP_IDLE;
      state_nxt.erase_armed = 1'b0;
    end else if (data == CMD_RESET) begin
      state_nxt.step        = STEP_IDLE;
      state_nxt.erase_armed = 1'b0;
      state_nxt.id_mode     = 1'b0;
    end else begin
      case (state.step)
        STEP_UNLOCK1: begin
          if (address == UNLOCK_B && data == DATA_UNLOCK_B) begin
            state_nxt.step = STEP_UNLOCK2;
          end else begin
            err = 1'b1;
          end
        end
        STEP_UNLOCK2: begin
          if (state.erase_armed) begin
            case (data)
              CMD_SECTOR: begin
                result.action         = ACT_SECTOR;
                result.action_address = address & SECTOR_MASK;
              end
              CMD_BLOCK: begin
                result.action         = ACT_BLOCK;
                result.action_address = address & BLOCK_MASK;
              end
              CMD_CHIP: begin
                result.action = ACT_CHIP;
              end
              default: begin
                err = 1'b1;
              end
            endcase
            state_nxt.step        = STEP_IDLE;
            state_nxt.erase_armed = 1'b0;
          end else if (address != UNLOCK_A) begin
            err = 1'b1;
          end else begin
            case (data)
              CMD_PROGRAM: begin
                state_nxt.step = STEP_PROGRAM;
              end
              CMD_ID_ENTRY: begin
                state_nxt.step        = STEP_IDLE;
                state_nxt.erase_armed = 1'b0;
                state_nxt.id_mode     = 1'b1;
              end
              CMD_ERASE: begin
                state_nxt.step        = STEP_IDLE;
                state_nxt.erase_armed = 1'b1;
              end
              default: begin
                err = 1'b1;
              end
            endcase
          end
        end
        default: begin
          // Idle, and any code outside the one-hot set, expects the first unlock.
          if (address == UNLOCK_A && data == DATA_UNLOCK_A) begin
            state_nxt.step = STEP_UNLOCK1;
          end else begin
            err = 1'b1;
          end
        end
      endcase
    end

    if (err) begin
      state_nxt.step        = STEP_IDLE;
      state_nxt.erase_armed = 1'b0;
    end

    result.in_id_mode     = state_nxt.id_mode;
    result.sequence_error = err;
  end

endmodule

[rtl/flash_command_sequence_decoder_core.sv]
// Top level of the flash command sequence decoder: state, config and result buffering.
//
// Decodes the software command sequences that a driver issues to a byte-wide
// flash. Every request on the input channel is one bus access (read or write)
// and produces exactly one result request: the array action it calls for
// (program, sector/block/chip erase, array read, ID read or none), its target
// address and byte, whether ID mode is active afterwards, and a one-shot flag
// when a write broke an unlock sequence. The sequence state is updated by a
// few compares at the clock edge that accepts the request, and the result
// lands in the output register, so one request per cycle is sustained while
// out_stall stays low. A second result register acts as a skid stage, which
// lets the input accept a request while the current result waits on
// out_stall; in_stall rises only when both registers hold results. The
// manufacturer and device ID bytes are written through the cfg port (index 0
// and 1) and should only be changed while no request is in flight.
module flash_command_sequence_decoder_core (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    cfg_we,
  input  logic [fcsd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [fcsd_pkg::BYTE_BITS-1:0]          cfg_wdata,

  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_operation,
  input  logic [fcsd_pkg::ADDRESS_BITS-1:0]       in_address,
  input  logic [fcsd_pkg::BYTE_BITS-1:0]          in_data,

  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [fcsd_pkg::ACTION_BITS-1:0]        out_action,
  output logic [fcsd_pkg::ADDRESS_BITS-1:0]       out_action_address,
  output logic [fcsd_pkg::BYTE_BITS-1:0]          out_action_byte,
  output logic                                    out_in_id_mode,
  output logic                                    out_sequence_error
);
  import fcsd_pkg::*;

  seq_state_t           state_r;
  seq_state_t           state_nxt;
  logic [BYTE_BITS-1:0] mfr_code_r;
  logic [BYTE_BITS-1:0] dev_code_r;

  result_t              result;
  result_t              out_data_r;
  result_t              skid_data_r;
  logic                 out_valid_r;
  logic                 skid_valid_r;

  logic                 in_accept;
  logic                 out_free;

  // The input is held off only when both result registers are occupied.
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  // The output register can take a new result this cycle.
  assign out_free  = !out_valid_r || !out_stall;

  fcsd_decode u_decode (
    .state             (state_r),
    .operation         (in_operation),
    .address           (in_address),
    .data              (in_data),
    .manufacturer_code (mfr_code_r),
    .device_code       (dev_code_r),
    .state_nxt         (state_nxt),
    .result            (result)
  );

  // Sequence state and ID codes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.step        <= STEP_IDLE;
      state_r.erase_armed <= 1'b0;
      state_r.id_mode     <= 1'b0;
      mfr_code_r          <= MFR_RESET;
      dev_code_r          <= DEV_RESET;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MANUFACTURER: mfr_code_r <= cfg_wdata;
          REG_DEVICE:       dev_code_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Occupancy of the output and skid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        // A waiting skid result goes first; no request is accepted then.
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_accept) begin
        out_data_r <= result;
      end
    end else if (in_accept) begin
      skid_data_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_data_r.action;
  assign out_action_address = out_data_r.action_address;
  assign out_action_byte    = out_data_r.action_byte;
  assign out_in_id_mode     = out_data_r.in_id_mode;
  assign out_sequence_error = out_data_r.sequence_error;

endmodule
